[src/expression_syntax_checker_unit_defines.svh]
// Assertion macros for the expression syntax checker.
`ifndef EXPRESSION_SYNTAX_CHECKER_UNIT_DEFINES_SVH
`define EXPRESSION_SYNTAX_CHECKER_UNIT_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define ESC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define ESC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[src/esc_pkg.sv]
// Types and constants shared by the expression syntax checker files.
package esc_pkg;

  localparam int CHAR_W  = 8;
  localparam int CAUSE_W = 3;

  // Token classes; CLS_NONE means no token seen yet.
  typedef enum logic [2:0] {
    CLS_NONE  = 3'd0,
    CLS_FUNC  = 3'd1,
    CLS_OPER  = 3'd2,
    CLS_OPEN  = 3'd3,
    CLS_CLOSE = 3'd4,
    CLS_DIGIT = 3'd5,
    CLS_POINT = 3'd6,
    CLS_VAR   = 3'd7
  } cls_t;

  // Partial function name codes; NM_DONE marks a completed name.
  typedef enum logic [3:0] {
    NM_IDLE = 4'd0,
    NM_S    = 4'd1,
    NM_SI   = 4'd2,
    NM_SQ   = 4'd3,
    NM_SQR  = 4'd4,
    NM_C    = 4'd5,
    NM_CO   = 4'd6,
    NM_CT   = 4'd7,
    NM_T    = 4'd8,
    NM_L    = 4'd9,
    NM_E    = 4'd10,
    NM_EX   = 4'd11,
    NM_DONE = 4'd15
  } name_t;

  typedef enum logic [CAUSE_W-1:0] {
    CAUSE_OK    = 3'd0,
    CAUSE_UNDER = 3'd1,
    CAUSE_UNBAL = 3'd2,
    CAUSE_DEPTH = 3'd3,
    CAUSE_CHAR  = 3'd4,
    CAUSE_FIRST = 3'd5,
    CAUSE_LAST  = 3'd6,
    CAUSE_SUCC  = 3'd7
  } cause_t;

  typedef struct packed {
    logic under;
    logic depth;
    logic bad_char;
    logic bad_first;
    logic bad_succ;
  } err_t;

  // Token stage result: next partial name, last token class, new errors.
  typedef struct packed {
    name_t prefix;
    cls_t  cls;
    err_t  err;
  } tok_res_t;

endpackage

[src/esc_channels.sv]
// Valid/ready channel interfaces for the character input and the verdict output.
interface esc_in_if;
  logic                          valid;
  logic                          ready;
  logic [esc_pkg::CHAR_W-1:0]    char_code;
  logic                          is_last;

  modport source(output valid, output char_code, output is_last, input ready);
  modport sink(input valid, input char_code, input is_last, output ready);
endinterface

interface esc_out_if;
  logic                          valid;
  logic                          ready;
  logic                          is_valid;
  logic [esc_pkg::CAUSE_W-1:0]   fail_cause;

  modport source(output valid, output is_valid, output fail_cause, input ready);
  modport sink(input valid, input is_valid, input fail_cause, output ready);
endinterface

[src/esc_token.sv]
// Tokenizer step: function name tracking, token classing and order checks.
module esc_token (
  input  logic [esc_pkg::CHAR_W-1:0] char_i,
  input  esc_pkg::name_t             prefix_i,
  input  esc_pkg::cls_t              prev_i,
  output esc_pkg::tok_res_t          res_o
);

  function automatic esc_pkg::name_t name_next(input esc_pkg::name_t p,
                                               input logic [esc_pkg::CHAR_W-1:0] c);
    esc_pkg::name_t r;
    r = esc_pkg::NM_IDLE;
    case (p)
      esc_pkg::NM_IDLE: begin
        if (c == "s") r = esc_pkg::NM_S;
        else if (c == "c") r = esc_pkg::NM_C;
        else if (c == "t") r = esc_pkg::NM_T;
        else if (c == "l") r = esc_pkg::NM_L;
        else if (c == "e") r = esc_pkg::NM_E;
      end
      esc_pkg::NM_S: begin
        if (c == "i") r = esc_pkg::NM_SI;
        else if (c == "q") r = esc_pkg::NM_SQ;
      end
      esc_pkg::NM_SI:  if (c == "n") r = esc_pkg::NM_DONE;
      esc_pkg::NM_SQ:  if (c == "r") r = esc_pkg::NM_SQR;
      esc_pkg::NM_SQR: if (c == "t") r = esc_pkg::NM_DONE;
      esc_pkg::NM_C: begin
        if (c == "o") r = esc_pkg::NM_CO;
        else if (c == "t") r = esc_pkg::NM_CT;
      end
      esc_pkg::NM_CO:  if (c == "s") r = esc_pkg::NM_DONE;
      esc_pkg::NM_CT:  if (c == "g") r = esc_pkg::NM_DONE;
      esc_pkg::NM_T:   if (c == "g") r = esc_pkg::NM_DONE;
      esc_pkg::NM_L:   if (c == "n" || c == "g") r = esc_pkg::NM_DONE;
      esc_pkg::NM_E:   if (c == "x") r = esc_pkg::NM_EX;
      esc_pkg::NM_EX:  if (c == "p") r = esc_pkg::NM_DONE;
      default:         r = esc_pkg::NM_IDLE;
    endcase
    return r;
  endfunction

  function automatic esc_pkg::cls_t single_class(input logic [esc_pkg::CHAR_W-1:0] c);
    esc_pkg::cls_t k;
    k = esc_pkg::CLS_NONE;
    if (c inside {["0":"9"]}) k = esc_pkg::CLS_DIGIT;
    else if (c == "(") k = esc_pkg::CLS_OPEN;
    else if (c == ")") k = esc_pkg::CLS_CLOSE;
    else if (c inside {"+", "-", "/", "*"}) k = esc_pkg::CLS_OPER;
    else if (c inside {",", "."}) k = esc_pkg::CLS_POINT;
    else if (c inside {"X", "Y"}) k = esc_pkg::CLS_VAR;
    return k;
  endfunction

  function automatic logic may_follow(input esc_pkg::cls_t p, input esc_pkg::cls_t k);
    logic ok;
    case (p)
      esc_pkg::CLS_FUNC:  ok = (k == esc_pkg::CLS_OPEN);
      esc_pkg::CLS_OPER:  ok = k inside {esc_pkg::CLS_OPEN, esc_pkg::CLS_VAR,
                                         esc_pkg::CLS_DIGIT};
      esc_pkg::CLS_OPEN:  ok = k inside {esc_pkg::CLS_OPEN, esc_pkg::CLS_DIGIT,
                                         esc_pkg::CLS_VAR, esc_pkg::CLS_FUNC};
      esc_pkg::CLS_DIGIT: ok = k inside {esc_pkg::CLS_POINT, esc_pkg::CLS_CLOSE,
                                         esc_pkg::CLS_DIGIT, esc_pkg::CLS_OPER};
      esc_pkg::CLS_POINT: ok = (k == esc_pkg::CLS_DIGIT);
      esc_pkg::CLS_CLOSE: ok = k inside {esc_pkg::CLS_CLOSE, esc_pkg::CLS_OPER};
      esc_pkg::CLS_VAR:   ok = k inside {esc_pkg::CLS_OPER, esc_pkg::CLS_CLOSE};
      default:            ok = 1'b1;
    endcase
    return ok;
  endfunction

  esc_pkg::name_t cont_name;
  esc_pkg::name_t start_name;
  esc_pkg::cls_t  single_cls;
  esc_pkg::cls_t  tok_cls;
  logic           tok_take;
  logic           fresh;
  logic           first_ok;

  assign cont_name  = name_next(prefix_i, char_i);
  assign start_name = name_next(esc_pkg::NM_IDLE, char_i);
  assign single_cls = single_class(char_i);

  always_comb begin
    res_o.prefix = prefix_i;
    res_o.cls    = prev_i;
    res_o.err    = '0;
    tok_cls      = single_cls;
    tok_take     = 1'b0;
    fresh        = 1'b1;

    if (prefix_i != esc_pkg::NM_IDLE) begin
      if (cont_name == esc_pkg::NM_DONE) begin
        res_o.prefix = esc_pkg::NM_IDLE;
        tok_cls      = esc_pkg::CLS_FUNC;
        tok_take     = 1'b1;
        fresh        = 1'b0;
      end else if (cont_name != esc_pkg::NM_IDLE) begin
        res_o.prefix = cont_name;
        fresh        = 1'b0;
      end else begin
        // broken name: drop it and read this character afresh
        res_o.err.bad_char = 1'b1;
        res_o.prefix       = esc_pkg::NM_IDLE;
      end
    end

    if (fresh) begin
      if (single_cls != esc_pkg::CLS_NONE) begin
        tok_take = 1'b1;
      end else if (start_name != esc_pkg::NM_IDLE) begin
        res_o.prefix = start_name;
      end else begin
        res_o.err.bad_char = 1'b1;
      end
    end

    first_ok = (tok_cls == esc_pkg::CLS_OPER && char_i == "-") ||
               (tok_cls inside {esc_pkg::CLS_OPEN, esc_pkg::CLS_VAR,
                                esc_pkg::CLS_DIGIT, esc_pkg::CLS_FUNC});

    if (tok_take) begin
      if (prev_i == esc_pkg::CLS_NONE) begin
        res_o.err.bad_first = !first_ok;
      end else begin
        res_o.err.bad_succ = !may_follow(prev_i, tok_cls);
      end
      res_o.cls = tok_cls;
    end
  end

endmodule

[src/expression_syntax_checker_unit.sv]
// Expression syntax checker top level: one formula character per beat.
//
// Usage: in_ch carries one ASCII character per beat in char_code, with is_last
// set on the final character of a formula. Only the final character yields a
// result: out_ch carries is_valid and fail_cause (smallest failing cause code).
// Throughput: one character per cycle while in_ch.ready is high, set by the
// single register stage that holds depth, partial name, last token class and
// the sticky error flags. A verdict enters the output register if that is empty
// or being taken, else the skid entry; the next formula then starts clean.
// Reset (rst_n low, synchronous) clears all formula state and empties the
// output; in_ch.ready is high right after reset.
// Stall: verdicts sit in a two-entry output stage (output register plus skid),
// so characters keep flowing while one verdict waits; in_ch.ready drops only
// while both entries hold verdicts that the receiver has not taken.
// Parenthesis depth saturates at DEPTH_LIMIT and flags an overflow.
`include "expression_syntax_checker_unit_defines.svh"

module expression_syntax_checker_unit #(
  parameter int DEPTH_LIMIT = 255
) (
  input  logic      clk,
  input  logic      rst_n,
  esc_in_if.sink    in_ch,
  esc_out_if.source out_ch
);

  localparam int DW = $clog2(DEPTH_LIMIT + 1);
  localparam logic [DW-1:0] DLIM = DW'(DEPTH_LIMIT);

  typedef struct packed {
    logic            is_valid;
    esc_pkg::cause_t cause;
  } verdict_t;

  logic [DW-1:0]     depth_r, depth_nxt;
  esc_pkg::name_t    prefix_r;
  esc_pkg::cls_t     prev_r;
  esc_pkg::err_t     err_r, err_nxt;
  esc_pkg::tok_res_t tok;

  logic     out_v_r, skid_v_r;
  verdict_t out_r, skid_r, verdict;

  logic accept, push, pop;

  assign in_ch.ready = !skid_v_r;
  assign accept      = in_ch.valid && in_ch.ready;
  assign push        = accept && in_ch.is_last;
  assign pop         = out_v_r && out_ch.ready;

  esc_token u_token (
    .char_i   (in_ch.char_code),
    .prefix_i (prefix_r),
    .prev_i   (prev_r),
    .res_o    (tok)
  );

  always_comb begin
    depth_nxt = depth_r;
    err_nxt   = err_r | tok.err;
    if (in_ch.char_code == "(") begin
      if (depth_r >= DLIM) err_nxt.depth = 1'b1;
      else depth_nxt = depth_r + DW'(1);
    end else if (in_ch.char_code == ")") begin
      if (depth_r == '0) err_nxt.under = 1'b1;
      else depth_nxt = depth_r - DW'(1);
    end
    // a name still open at the end counts as a bad name
    if (in_ch.is_last && tok.prefix != esc_pkg::NM_IDLE) err_nxt.bad_char = 1'b1;
  end

  always_comb begin
    if (err_nxt.under) verdict.cause = esc_pkg::CAUSE_UNDER;
    else if (depth_nxt != '0) verdict.cause = esc_pkg::CAUSE_UNBAL;
    else if (err_nxt.depth) verdict.cause = esc_pkg::CAUSE_DEPTH;
    else if (err_nxt.bad_char) verdict.cause = esc_pkg::CAUSE_CHAR;
    else if (err_nxt.bad_first) verdict.cause = esc_pkg::CAUSE_FIRST;
    else if (!(tok.cls inside {esc_pkg::CLS_CLOSE, esc_pkg::CLS_VAR, esc_pkg::CLS_DIGIT}))
      verdict.cause = esc_pkg::CAUSE_LAST;
    else if (err_nxt.bad_succ) verdict.cause = esc_pkg::CAUSE_SUCC;
    else verdict.cause = esc_pkg::CAUSE_OK;
    verdict.is_valid = (verdict.cause == esc_pkg::CAUSE_OK);
  end

  // formula state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      depth_r  <= '0;
      prefix_r <= esc_pkg::NM_IDLE;
      prev_r   <= esc_pkg::CLS_NONE;
      err_r    <= '0;
    end else if (accept) begin
      if (in_ch.is_last) begin
        depth_r  <= '0;
        prefix_r <= esc_pkg::NM_IDLE;
        prev_r   <= esc_pkg::CLS_NONE;
        err_r    <= '0;
      end else begin
        depth_r  <= depth_nxt;
        prefix_r <= tok.prefix;
        prev_r   <= tok.cls;
        err_r    <= err_nxt;
      end
    end
  end

  // output register and skid entry
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else if (!out_v_r || pop) begin
      out_v_r  <= skid_v_r || push;
      skid_v_r <= 1'b0;
    end else if (push) begin
      skid_v_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_v_r || pop) begin
      out_r <= skid_v_r ? skid_r : verdict;
    end else if (push) begin
      skid_r <= verdict;
    end
  end

  assign out_ch.valid      = out_v_r;
  assign out_ch.is_valid   = out_r.is_valid;
  assign out_ch.fail_cause = out_r.cause;

  `ESC_ASSERT_NOW(a_verdict_consistent, out_v_r, out_r.is_valid == (out_r.cause == esc_pkg::CAUSE_OK), "verdict flag disagrees with cause")
  `ESC_ASSERT_NOW(a_skid_behind_out, skid_v_r, out_v_r, "skid entry held while output register empty")
  `ESC_ASSERT_NOW(a_depth_bound, 1'b1, depth_r <= DLIM, "parenthesis depth above limit")
  `ESC_ASSERT_NEXT(a_clear_after_last, push, depth_r == '0 && prefix_r == esc_pkg::NM_IDLE && prev_r == esc_pkg::CLS_NONE && err_r == '0, "formula state not cleared after last character")

endmodule
